// File: sv/ic64_pkg.sv
// Shared types and constants of the 64-channel interrupt controller.
package ic64_pkg;

  localparam int NUM_LINES   = 64;
  localparam int HALF_W      = 32;
  localparam int ROUTE_WORDS = NUM_LINES / 4;
  localparam int ROUTE_IDX_W = $clog2(ROUTE_WORDS);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] CMD_READ   = 2'd0;
  localparam logic [1:0] CMD_WRITE  = 2'd1;
  localparam logic [1:0] CMD_SAMPLE = 2'd2;

  localparam logic [5:0] ROUTE_BASE = 6'(32'h60 / 4);
  localparam logic [5:0] ROUTE_LAST = 6'(32'h60 / 4 + ROUTE_WORDS - 1);

  localparam logic [4:0] PAIR_ACTIVE  = 5'd0;
  localparam logic [4:0] PAIR_PENDING = 5'd2;
  localparam logic [4:0] PAIR_EN_SET  = 5'd4;
  localparam logic [4:0] PAIR_EN_CLR  = 5'd6;
  localparam logic [4:0] PAIR_ENABLE  = 5'd8;
  localparam logic [4:0] PAIR_MASK    = 5'd10;

  localparam logic [6:0] NO_IRQ = 7'd64;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_RD_ACTIVE,
    OP_RD_PENDING,
    OP_RD_ENABLE,
    OP_RD_MASK,
    OP_RD_ROUTE,
    OP_WR_EN_SET,
    OP_WR_EN_CLR,
    OP_WR_MASK,
    OP_WR_ROUTE,
    OP_SAMPLE
  } op_kind_t;

  typedef struct packed {
    op_kind_t                kind;
    logic                    upper;
    logic [ROUTE_IDX_W-1:0]  route_idx;
    logic [NUM_LINES-1:0]    data;
  } op_t;

endpackage

// File: sv/ic64_front.sv
// Front end: accepts beats and classifies them into queued operations.
module ic64_front (
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     command,
  input  logic [5:0]                     word_index,
  input  logic [31:0]                    write_data,
  input  logic [63:0]                    line_levels,
  output logic                           push_valid,
  input  logic                           push_ready,
  output ic64_pkg::op_t                  push_op
);

  logic       is_route;
  logic [5:0] route_off;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign is_route   = word_index inside {[ic64_pkg::ROUTE_BASE:ic64_pkg::ROUTE_LAST]};
  assign route_off  = word_index - ic64_pkg::ROUTE_BASE;

  always_comb begin
    push_op.kind      = ic64_pkg::OP_IDLE;
    push_op.upper     = word_index[0];
    push_op.route_idx = route_off[ic64_pkg::ROUTE_IDX_W-1:0];
    push_op.data      = {32'b0, write_data};
    case (command)
      ic64_pkg::CMD_READ: begin
        if (is_route) begin
          push_op.kind = ic64_pkg::OP_RD_ROUTE;
        end else begin
          case (word_index[5:1])
            ic64_pkg::PAIR_ACTIVE:  push_op.kind = ic64_pkg::OP_RD_ACTIVE;
            ic64_pkg::PAIR_PENDING: push_op.kind = ic64_pkg::OP_RD_PENDING;
            ic64_pkg::PAIR_ENABLE:  push_op.kind = ic64_pkg::OP_RD_ENABLE;
            ic64_pkg::PAIR_MASK:    push_op.kind = ic64_pkg::OP_RD_MASK;
            default:                push_op.kind = ic64_pkg::OP_IDLE;
          endcase
        end
      end
      ic64_pkg::CMD_WRITE: begin
        if (is_route) begin
          push_op.kind = ic64_pkg::OP_WR_ROUTE;
        end else begin
          case (word_index[5:1])
            ic64_pkg::PAIR_EN_SET: push_op.kind = ic64_pkg::OP_WR_EN_SET;
            ic64_pkg::PAIR_EN_CLR: push_op.kind = ic64_pkg::OP_WR_EN_CLR;
            ic64_pkg::PAIR_MASK:   push_op.kind = ic64_pkg::OP_WR_MASK;
            default:               push_op.kind = ic64_pkg::OP_IDLE;
          endcase
        end
      end
      ic64_pkg::CMD_SAMPLE: begin
        push_op.kind = ic64_pkg::OP_SAMPLE;
        push_op.data = line_levels;
      end
      default: push_op.kind = ic64_pkg::OP_IDLE;
    endcase
  end

endmodule

// File: sv/ic64_queue.sv
// Short operation queue between the front end and the execution back end.
module ic64_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  ic64_pkg::op_t push_op,
  output logic          pop_valid,
  input  logic          pop_ready,
  output ic64_pkg::op_t pop_op
);

  ic64_pkg::op_t                 entries [ic64_pkg::QUEUE_DEPTH];
  logic [ic64_pkg::QPTR_W-1:0]   wr_ptr;
  logic [ic64_pkg::QPTR_W-1:0]   rd_ptr;
  logic [ic64_pkg::QCNT_W-1:0]   count;
  logic                          push;
  logic                          pop;

  assign push_ready = (count != ic64_pkg::QCNT_W'(ic64_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_op     = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + ic64_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + ic64_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + ic64_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - ic64_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

// File: sv/ic64_back.sv
// Back end: register state, pending and priority logic, and the result register.
module ic64_back #(
  parameter int NUM_CHANNELS = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  ic64_pkg::op_t pop_op,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [31:0]   read_data,
  output logic          irq_request,
  output logic [6:0]    irq_number
);

  logic [63:0] enable_bits;
  logic [63:0] mask_bits;
  logic [63:0] sampled_lines;
  logic [31:0] route_words [ic64_pkg::ROUTE_WORDS];
  logic [63:0] route_hot [ic64_pkg::NUM_LINES];
  logic [63:0] route_hot_next [ic64_pkg::NUM_LINES];
  logic [7:0]  line_byte [ic64_pkg::NUM_LINES];

  logic [63:0] pending;
  logic [63:0] active;
  logic [4:0]  lo_num;
  logic [4:0]  hi_num;
  logic [6:0]  irq_num_now;
  logic        route_wr;

  logic        ex_valid;
  logic [31:0] ex_data;
  logic [31:0] ex_data_next;
  logic        pop;
  logic        out_load;

  assign out_load  = !out_valid || out_ready;
  assign pop_ready = !ex_valid || out_load;
  assign pop       = pop_valid && pop_ready;
  assign route_wr  = pop && (pop_op.kind == ic64_pkg::OP_WR_ROUTE);

  always_comb begin
    for (int l = 0; l < ic64_pkg::NUM_LINES; l++) begin
      line_byte[l] = pop_op.data[(l % 4) * 8 +: 8];
      route_hot_next[l] = route_hot[l];
      if (route_wr && (pop_op.route_idx == ic64_pkg::ROUTE_IDX_W'(l / 4))) begin
        for (int c = 0; c < 64; c++) begin
          route_hot_next[l][c] = (line_byte[l] == 8'(c)) && (c < NUM_CHANNELS);
        end
      end
    end
  end

  always_comb begin
    pending = '0;
    for (int l = 0; l < ic64_pkg::NUM_LINES; l++) begin
      if (sampled_lines[l]) begin
        pending = pending | route_hot[l];
      end
    end
  end

  assign active = pending & enable_bits & ~mask_bits;

  always_comb begin
    lo_num = '0;
    hi_num = '0;
    for (int i = 0; i < ic64_pkg::HALF_W; i++) begin
      if (active[i]) begin
        lo_num = 5'(i);
      end
      if (active[ic64_pkg::HALF_W + i]) begin
        hi_num = 5'(i);
      end
    end
    if (|active[31:0]) begin
      irq_num_now = {2'b00, lo_num};
    end else if (|active[63:32]) begin
      irq_num_now = {2'b01, hi_num};
    end else begin
      irq_num_now = ic64_pkg::NO_IRQ;
    end
  end

  always_comb begin
    case (pop_op.kind)
      ic64_pkg::OP_RD_ACTIVE:  ex_data_next = pop_op.upper ? active[63:32] : active[31:0];
      ic64_pkg::OP_RD_PENDING: ex_data_next = pop_op.upper ? pending[63:32] : pending[31:0];
      ic64_pkg::OP_RD_ENABLE:
        ex_data_next = pop_op.upper ? enable_bits[63:32] : enable_bits[31:0];
      ic64_pkg::OP_RD_MASK:    ex_data_next = pop_op.upper ? mask_bits[63:32] : mask_bits[31:0];
      ic64_pkg::OP_RD_ROUTE:   ex_data_next = route_words[pop_op.route_idx];
      default:                 ex_data_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_bits   <= '0;
      mask_bits     <= '1;
      sampled_lines <= '0;
      for (int w = 0; w < ic64_pkg::ROUTE_WORDS; w++) begin
        route_words[w] <= '1;
      end
      for (int l = 0; l < ic64_pkg::NUM_LINES; l++) begin
        route_hot[l] <= '0;
      end
    end else begin
      for (int l = 0; l < ic64_pkg::NUM_LINES; l++) begin
        route_hot[l] <= route_hot_next[l];
      end
      if (pop) begin
        case (pop_op.kind)
          ic64_pkg::OP_WR_EN_SET: begin
            if (pop_op.upper) begin
              enable_bits[63:32] <= enable_bits[63:32] | pop_op.data[31:0];
            end else begin
              enable_bits[31:0] <= enable_bits[31:0] | pop_op.data[31:0];
            end
          end
          ic64_pkg::OP_WR_EN_CLR: begin
            if (pop_op.upper) begin
              enable_bits[63:32] <= enable_bits[63:32] & ~pop_op.data[31:0];
            end else begin
              enable_bits[31:0] <= enable_bits[31:0] & ~pop_op.data[31:0];
            end
          end
          ic64_pkg::OP_WR_MASK: begin
            if (pop_op.upper) begin
              mask_bits[63:32] <= pop_op.data[31:0];
            end else begin
              mask_bits[31:0] <= pop_op.data[31:0];
            end
          end
          ic64_pkg::OP_WR_ROUTE: route_words[pop_op.route_idx] <= pop_op.data[31:0];
          ic64_pkg::OP_SAMPLE:   sampled_lines <= pop_op.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ex_data <= ex_data_next;
    end
    if (out_load && ex_valid) begin
      read_data   <= ex_data;
      irq_request <= |active;
      irq_number  <= irq_num_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        ex_valid <= 1'b1;
      end else if (out_load) begin
        ex_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= ex_valid;
      end
    end
  end

  a_req_matches_num: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (irq_request == (irq_number != ic64_pkg::NO_IRQ)))
    else $error("irq_request disagrees with irq_number");

  a_num_in_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && irq_request) |-> (irq_number < 7'(NUM_CHANNELS)))
    else $error("irq_number names an unimplemented channel");

  a_state_frozen_in_stall: assert property (@(posedge clk) disable iff (rst)
    (ex_valid && !out_load) |=>
      ($stable(enable_bits) && $stable(mask_bits) && $stable(sampled_lines)))
    else $error("state changed while the execute stage was stalled");

  a_no_phantom_pending: assert property (@(posedge clk) disable iff (rst)
    (pending >> NUM_CHANNELS) == 64'd0)
    else $error("unimplemented channel shows pending");

endmodule

// File: sv/interrupt_controller_64_source.sv
// Top level of the 64-channel level interrupt controller.
// Each input beat is a register read, a register write or a sample of the
// 64 raw interrupt lines, selected by command; each beat yields exactly one
// output beat with read_data, irq_request and irq_number.
// Both channels use valid and ready; a beat moves when both are high.
// The front end decodes the beat into an operation and pushes it into a
// two-entry queue; the back end pops it, updates the register state and
// registers the result.
// A result is held in the queue, then in ex_data, then in read_data.
// With out_ready high, one beat per cycle is sustained in both directions;
// the execute stage and the output register each take one operation per cycle.
// irq_request and irq_number show the state after the beat's own update.
// Reset clears the enables and the sampled lines, sets all mask bits and
// sets every routing byte to 0xff, so no channel is active.
// When the receiver stalls, the output beat holds, the back end stops
// popping and the queue fills; in_ready falls once the queue is full.
module interrupt_controller_64_source #(
  parameter int NUM_CHANNELS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [5:0]  word_index,
  input  logic [31:0] write_data,
  input  logic [63:0] line_levels,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] read_data,
  output logic        irq_request,
  output logic [6:0]  irq_number
);

  logic          push_valid;
  logic          push_ready;
  ic64_pkg::op_t push_op;
  logic          pop_valid;
  logic          pop_ready;
  ic64_pkg::op_t pop_op;

  ic64_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .word_index  (word_index),
    .write_data  (write_data),
    .line_levels (line_levels),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_op     (push_op)
  );

  ic64_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_op     (pop_op)
  );

  ic64_back #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_op      (pop_op),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .read_data   (read_data),
    .irq_request (irq_request),
    .irq_number  (irq_number)
  );

endmodule
